// ===== hw/rtl/sni_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed neighbor index package
// Shared widths, limits, register codes and the multiply-add operand word.
// ----------------------------------------------------------------------------
package sni_pkg;

  // Seed and alphabet limits.
  localparam int SEED_LEN_MAX = 4;
  localparam int ALPHA_MAX    = 16;

  // Field widths.
  localparam int SYM_W  = 4;
  localparam int IDX_W  = 16;
  localparam int LEN_W  = 3;
  localparam int RAD_W  = 5;
  localparam int POS_W  = $clog2(SEED_LEN_MAX);
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 5;

  // Configuration register indexes.
  localparam logic [CFG_IW-1:0] CFG_SEED_LENGTH       = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_ALPHABET_SIZE     = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_NEIGHBOR_DISTANCE = 2'd2;

  // Operand word for the shared multiply-add unit: res = acc +/- a * b.
  typedef struct packed {
    logic [IDX_W-1:0] acc;
    logic [RAD_W-1:0] mul_a;
    logic [IDX_W-1:0] mul_b;
    logic             sub;
  } mac_op_t;

endpackage

// ===== hw/rtl/sni_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiply-add unit
// Computes acc plus or minus a small radix operand times a 16-bit index weight.
// ----------------------------------------------------------------------------
module sni_mac
  import sni_pkg::*;
(
  input  mac_op_t          op_i,
  output logic [IDX_W-1:0] res_o
);

  logic [RAD_W+IDX_W-1:0] prod;
  logic [IDX_W-1:0]       prod_lo;

  // All index arithmetic wraps modulo 2^16.
  assign prod    = {{IDX_W{1'b0}}, op_i.mul_a} * {{RAD_W{1'b0}}, op_i.mul_b};
  assign prod_lo = prod[IDX_W-1:0];
  assign res_o   = op_i.sub ? (op_i.acc - prod_lo) : (op_i.acc + prod_lo);

endmodule

// ===== hw/rtl/seed_neighbor_index_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed neighbor index generator
// Forms the mixed-radix index of a seed and, in distance-one mode, the index
// of every single-substitution neighbor; a new seed waits for the last word.
// ----------------------------------------------------------------------------
// Per seed, ST_BASE_A adds one digit per position and ST_BASE_B steps the
// weight between positions; ST_EMIT_SEED then issues the seed word. In
// distance-one mode ST_LOAD and ST_NEIGH walk the neighbors of each position.
// The single shared multiply-add unit serves all of these steps.
// A bad seed ends the walk at the first bad position with one bad-symbol word.
// Reset restores the registers to length 4, radix 10, distance 1; no sweep.
module seed_neighbor_index_generator
  import sni_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CFG_IW-1:0] cfg_index_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  // Seed input channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [SYM_W-1:0]  sym0_i,
  input  logic [SYM_W-1:0]  sym1_i,
  input  logic [SYM_W-1:0]  sym2_i,
  input  logic [SYM_W-1:0]  sym3_i,
  // Result output channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [IDX_W-1:0]  seed_index_o,
  output logic              last_o,
  output logic              bad_symbol_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BASE_A,
    ST_BASE_B,
    ST_EMIT_SEED,
    ST_LOAD,
    ST_NEIGH
  } state_e;

  // Configuration registers.
  logic [LEN_W-1:0] seed_len_q;
  logic [RAD_W-1:0] alpha_q;
  logic             dist_q;

  // Sequencer and datapath registers.
  state_e           state_q;
  logic [SYM_W-1:0] sym_q [SEED_LEN_MAX];
  logic [IDX_W-1:0] pw_q  [SEED_LEN_MAX];
  logic [POS_W-1:0] len_m1_q;
  logic [RAD_W-1:0] r_q;
  logic             nd_q;
  logic [POS_W-1:0] pos_q;
  logic [IDX_W-1:0] base_q;
  logic [IDX_W-1:0] p_q;
  logic [IDX_W-1:0] idx_q;
  logic [SYM_W-1:0] v_q;
  logic [SYM_W-1:0] k_q;

  // Output register.
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_last_q;
  logic             out_bad_q;

  logic             in_acc;
  logic             out_free;
  logic [POS_W-1:0] len_m1_c;
  logic [RAD_W-1:0] r_c;
  logic [SYM_W-1:0] r_m1;
  logic [SYM_W-1:0] sym_cur;
  logic             sym_bad;
  logic             wrap;
  logic             pos_end;
  logic             neigh_last;
  mac_op_t          mac_op;
  logic [IDX_W-1:0] mac_res;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_len_q <= LEN_W'(SEED_LEN_MAX);
      alpha_q    <= RAD_W'(10);
      dist_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEED_LENGTH:       seed_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_ALPHABET_SIZE:     alpha_q    <= cfg_data_i;
        CFG_NEIGHBOR_DISTANCE: dist_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Handshake status.
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Clamp the registers to their working ranges at accept time.
  always_comb begin
    if (seed_len_q == '0) begin
      len_m1_c = '0;
    end else if (seed_len_q > LEN_W'(SEED_LEN_MAX)) begin
      len_m1_c = POS_W'(SEED_LEN_MAX - 1);
    end else begin
      len_m1_c = POS_W'(seed_len_q - LEN_W'(1));
    end
    if (alpha_q < RAD_W'(2)) begin
      r_c = RAD_W'(2);
    end else if (alpha_q > RAD_W'(ALPHA_MAX)) begin
      r_c = RAD_W'(ALPHA_MAX);
    end else begin
      r_c = alpha_q;
    end
  end

  // Per-position helper terms.
  assign r_m1       = SYM_W'(r_q - RAD_W'(1));
  assign sym_cur    = sym_q[pos_q];
  assign sym_bad    = ({1'b0, sym_cur} >= r_q);
  assign wrap       = (v_q == r_m1);
  assign pos_end    = (k_q == r_m1);
  assign neigh_last = pos_end && (pos_q == len_m1_q);

  // Operand selection for the shared unit. In the neighbor walk the digit
  // steps by one weight, or falls back by (R-1) weights when it wraps to 0.
  always_comb begin
    mac_op = '0;
    case (state_q)
      ST_BASE_A: begin
        mac_op.acc   = base_q;
        mac_op.mul_a = {1'b0, sym_cur};
        mac_op.mul_b = p_q;
      end
      ST_BASE_B: begin
        mac_op.mul_a = r_q;
        mac_op.mul_b = p_q;
      end
      ST_NEIGH: begin
        mac_op.acc   = idx_q;
        mac_op.mul_a = wrap ? {1'b0, r_m1} : RAD_W'(1);
        mac_op.mul_b = pw_q[pos_q];
        mac_op.sub   = wrap;
      end
      default: mac_op = '0;
    endcase
  end

  sni_mac u_mac (
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  // Sequencer, datapath and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sym_q       <= '{default: '0};
      pw_q        <= '{default: '0};
      len_m1_q    <= '0;
      r_q         <= RAD_W'(2);
      nd_q        <= 1'b0;
      pos_q       <= '0;
      base_q      <= '0;
      p_q         <= '0;
      idx_q       <= '0;
      v_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_last_q  <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            sym_q[0] <= sym0_i;
            sym_q[1] <= sym1_i;
            sym_q[2] <= sym2_i;
            sym_q[3] <= sym3_i;
            len_m1_q <= len_m1_c;
            r_q      <= r_c;
            nd_q     <= dist_q;
            pos_q    <= '0;
            base_q   <= '0;
            p_q      <= IDX_W'(1);
            state_q  <= ST_BASE_A;
          end
        end
        // Accumulate one digit of the seed index, or report a bad symbol.
        ST_BASE_A: begin
          if (sym_bad) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_idx_q   <= '0;
              out_last_q  <= 1'b1;
              out_bad_q   <= 1'b1;
              state_q     <= ST_IDLE;
            end
          end else begin
            base_q       <= mac_res;
            pw_q[pos_q]  <= p_q;
            state_q      <= (pos_q == len_m1_q) ? ST_EMIT_SEED : ST_BASE_B;
          end
        end
        // Advance the digit weight to the next position.
        ST_BASE_B: begin
          p_q     <= mac_res;
          pos_q   <= pos_q + POS_W'(1);
          state_q <= ST_BASE_A;
        end
        ST_EMIT_SEED: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= base_q;
            out_last_q  <= !nd_q;
            out_bad_q   <= 1'b0;
            pos_q       <= '0;
            state_q     <= nd_q ? ST_LOAD : ST_IDLE;
          end
        end
        // Restart the walk at the seed index for the current position.
        ST_LOAD: begin
          idx_q   <= base_q;
          v_q     <= sym_cur;
          k_q     <= SYM_W'(1);
          state_q <= ST_NEIGH;
        end
        ST_NEIGH: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= mac_res;
            out_last_q  <= neigh_last;
            out_bad_q   <= 1'b0;
            idx_q       <= mac_res;
            v_q         <= wrap ? '0 : v_q + SYM_W'(1);
            k_q         <= k_q + SYM_W'(1);
            if (neigh_last) begin
              state_q <= ST_IDLE;
            end else if (pos_end) begin
              pos_q   <= pos_q + POS_W'(1);
              state_q <= ST_LOAD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign seed_index_o = out_idx_q;
  assign last_o       = out_last_q;
  assign bad_symbol_o = out_bad_q;

endmodule

// ===== hw/rtl/sni_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed neighbor index checker
// Port-level assertions on the generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sni_checker
  import sni_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [IDX_W-1:0] seed_index_o,
  input logic             last_o,
  input logic             bad_symbol_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(seed_index_o) && $stable(last_o) && $stable(bad_symbol_o)))
    else $error("stalled result word changed");

  // A bad seed gives a single word with index zero.
  a_bad_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_symbol_o) |-> (last_o && (seed_index_o == '0)))
    else $error("bad symbol word is not a final zero index");

  // The block is busy right after it takes a seed.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after seed accept");

  // No new seed is taken while a result word before the last of a seed is shown.
  a_busy_mid_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> in_stall_o)
    else $error("input open before the final word of a seed");

endmodule

bind seed_neighbor_index_generator sni_checker u_sni_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .seed_index_o (seed_index_o),
  .last_o       (last_o),
  .bad_symbol_o (bad_symbol_o)
);
